>>> sv/etcd_pkg.sv
// Shared types and constants for the extra-tooth cam trigger decoder.
package etcd_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int TOOTH_TIME_W   = 32;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 24;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // register index, taken from paddr[2]
  localparam logic REG_CYL_COUNT  = 1'b0;
  localparam logic REG_CRANK_LOCK = 1'b1;

  localparam logic [2:0] CYL_RESET   = 3'd4;
  localparam logic [2:0] CYL_THREE   = 3'd3;
  localparam logic [2:0] TEETH_THREE = 3'd4;
  localparam logic [2:0] TEETH_FOUR  = 3'd5;

  typedef struct packed {
    logic [2:0] cyl_count;
    logic       crank_lock;
  } etcd_cfg_t;

  typedef struct packed {
    logic        has_sync;
    logic [2:0]  tooth_number;
    logic [2:0]  coil_end;
    logic        rev_start;
    logic [15:0] rev_count;
  } etcd_res_t;

endpackage

>>> sv/extra_tooth_cam_trigger_decoder.sv
// Top level: input register, decoder core, output register and APB config.
//
//  channel | dir | handshake         | word
//  in_     | in  | tvalid/tready     | tooth_time, cranking
//  out_    | out | tvalid/tready     | has_sync, tooth_number, coil_end, rev start/count
//  cfg_    | in  | APB, pready high  | cylinder_count @0x0, crank_lock_enable @0x4
//
// One word per cycle sustained while out_tready stays high; a word passes through the input
// register and then the output register before it is on out_.
// The state update (gap subtract, threshold compare) runs in the cycle the word
// leaves the input register for the output register.
// rst_n is synchronous: clears sync, counters, timestamps and both valid flags.
// A stall on out_ holds both registers; in_tready drops only when both are full
// and out_tready is low.
module extra_tooth_cam_trigger_decoder #(
  parameter int TIME_BITS = etcd_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [etcd_pkg::IN_DATA_W-1:0]      in_tdata,   // [31:0] tooth_time, [32] cranking
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] has_sync, [3:1] tooth_number, [6:4] coil_end, [7] revolution_start,
  // [23:8] revolution_count
  output logic [etcd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [etcd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [etcd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [etcd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import etcd_pkg::*;

  etcd_cfg_t cfg;
  etcd_res_t res;
  etcd_res_t out_res_r;

  logic                    s1_valid_r, s1_valid_nxt;
  logic [TOOTH_TIME_W-1:0] s1_time_r;
  logic                    s1_crank_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_adv;
  logic                    step;
  logic                    in_fire;

  etcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  etcd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (step),
    .tooth_time (s1_time_r),
    .cranking   (s1_crank_r),
    .res        (res)
  );

  assign out_adv       = !out_valid_r || out_tready;
  assign step          = s1_valid_r && out_adv;
  assign in_tready     = !s1_valid_r || out_adv;
  assign in_fire       = in_tvalid && in_tready;
  assign s1_valid_nxt  = in_tvalid || (s1_valid_r && !out_adv);
  assign out_valid_nxt = step || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_time_r  <= in_tdata[TOOTH_TIME_W-1:0];
      s1_crank_r <= in_tdata[TOOTH_TIME_W];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.rev_count, out_res_r.rev_start, out_res_r.coil_end,
                       out_res_r.tooth_number, out_res_r.has_sync};

`ifndef SYNTHESIS
  a_nosync_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[7:1] == 7'd0)
    else $error("result without sync carries tooth, coil or revolution start");

  a_rev_is_tooth_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[3:1] == 3'd1)
    else $error("revolution start not on tooth one");

  a_sync_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.has_sync |=> res.has_sync)
    else $error("sync dropped");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && s1_valid_r)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> sv/etcd_cfg.sv
// APB register block: cylinder count and crank lock enable.
module etcd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [etcd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [etcd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [etcd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output etcd_pkg::etcd_cfg_t            cfg
);
  import etcd_pkg::*;

  logic [2:0] cyl_r;
  logic       lock_r;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyl_r  <= CYL_RESET;
      lock_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CYL_COUNT:  cyl_r  <= pwdata[2:0];
        REG_CRANK_LOCK: lock_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CYL_COUNT:  prdata = {{(CFG_DATA_W-3){1'b0}}, cyl_r};
      REG_CRANK_LOCK: prdata = {{(CFG_DATA_W-1){1'b0}}, lock_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.cyl_count  = cyl_r;
  assign cfg.crank_lock = lock_r;

endmodule

>>> sv/etcd_core.sv
// Decoder state and per-tooth update: gap test, sync, tooth count, coil end.
module etcd_core #(
  parameter int TIME_BITS = etcd_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  etcd_pkg::etcd_cfg_t               cfg,
  input  logic                              step,
  input  logic [etcd_pkg::TOOTH_TIME_W-1:0] tooth_time,
  input  logic                              cranking,
  output etcd_pkg::etcd_res_t               res
);
  import etcd_pkg::*;

  logic                 sync_r, sync_nxt;
  logic [2:0]           tooth_r, tooth_nxt;
  logic [1:0]           seen_r, seen_nxt;     // saturates at 3, only ">= 2" matters
  logic [TIME_BITS-1:0] last_r;
  logic [TIME_BITS-1:0] prev_gap_r;           // last minus prior tooth time
  logic [15:0]          cycles_r, cycles_nxt;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] gap;
  logic [TIME_BITS-1:0] eighth;
  logic [4:0]           frac3;
  logic [TIME_BITS-1:0] tgt;
  logic                 three;
  logic [2:0]           teeth;
  logic                 rev;
  logic [2:0]           coil;

  if (TIME_BITS <= TOOTH_TIME_W) begin : g_narrow
    assign now = tooth_time[TIME_BITS-1:0];
  end else begin : g_wide
    assign now = {{(TIME_BITS-TOOTH_TIME_W){1'b0}}, tooth_time};
  end

  assign gap    = now - last_r;
  assign three  = (cfg.cyl_count == CYL_THREE);
  assign teeth  = three ? TEETH_THREE : TEETH_FOUR;
  assign eighth = prev_gap_r >> 3;
  assign frac3  = {2'b00, prev_gap_r[2:0]} + {1'b0, prev_gap_r[2:0], 1'b0};

  // floor(prev*3/8) exactly when cyl_count is not three: 3*(prev/8) + floor(3*(prev%8)/8); prev/4 for three
  always_comb begin
    if (three) begin
      tgt = prev_gap_r >> 2;
    end else begin
      tgt = (eighth << 1) + eighth + {{(TIME_BITS-2){1'b0}}, frac3[4:3]};
    end
  end

  always_comb begin
    sync_nxt   = sync_r;
    tooth_nxt  = tooth_r;
    cycles_nxt = cycles_r;
    rev        = 1'b0;
    coil       = 3'd0;
    seen_nxt   = (seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1;
    if (sync_r) begin
      if (tooth_r >= teeth) begin
        tooth_nxt  = 3'd1;
        cycles_nxt = cycles_r + 16'd1;
        rev        = 1'b1;
      end else begin
        tooth_nxt = tooth_r + 3'd1;
      end
      if (cfg.crank_lock && cranking && tooth_nxt >= 3'd1 && tooth_nxt <= 3'd4) begin
        coil = tooth_nxt;
      end
    end else if (seen_r >= 2'd2) begin
      if (gap < tgt) begin
        tooth_nxt = 3'd2;
        sync_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= 1'b0;
      tooth_r    <= 3'd0;
      seen_r     <= 2'd0;
      last_r     <= '0;
      prev_gap_r <= '0;
      cycles_r   <= 16'd0;
    end else if (step) begin
      sync_r     <= sync_nxt;
      tooth_r    <= tooth_nxt;
      seen_r     <= seen_nxt;
      last_r     <= now;
      prev_gap_r <= gap;
      cycles_r   <= cycles_nxt;
    end
  end

  assign res.has_sync     = sync_nxt;
  assign res.tooth_number = sync_nxt ? tooth_nxt : 3'd0;
  assign res.coil_end     = coil;
  assign res.rev_start    = rev;
  assign res.rev_count    = cycles_nxt;

endmodule
